@@ design/rcbhl_pkg.sv @@
// Package for the RC brake and hazard light controller.
// It holds the throttle state and register index types, the fixed levels
// and limits, and the blink phase function. It depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rcbhl_pkg;

	// Throttle states in their stored encoding.
	typedef enum logic [1:0] {
		THR_ACCEL   = 2'd0,
		THR_NEUTRAL = 2'd1,
		THR_BRAKE   = 2'd2
	} thr_state_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_BRAKE_THRESHOLD   = 3'd0,
		REG_ACCEL_THRESHOLD   = 3'd1,
		REG_TRIGGER_DROP      = 3'd2,
		REG_POSITION_LEVEL    = 3'd3,
		REG_NEUTRAL_WINDOW_US = 3'd4,
		REG_FRESH_WINDOW_US   = 3'd5,
		REG_HAZARD_THRESHOLD  = 3'd6,
		REG_BAD_LIMIT         = 3'd7
	} cfg_reg_t;

	// Field widths.
	localparam int unsigned NOW_W   = 32;
	localparam int unsigned WIDTH_W = 15;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned CFG_W   = 20;

	// Register reset values.
	localparam logic [11:0] BRAKE_THRESHOLD_RST   = 12'd1450;
	localparam logic [11:0] ACCEL_THRESHOLD_RST   = 12'd1550;
	localparam logic [7:0]  TRIGGER_DROP_RST      = 8'd20;
	localparam logic [7:0]  POSITION_LEVEL_RST    = 8'd31;
	localparam logic [19:0] NEUTRAL_WINDOW_US_RST = 20'd50000;
	localparam logic [19:0] FRESH_WINDOW_US_RST   = 20'd100000;
	localparam logic [11:0] HAZARD_THRESHOLD_RST  = 12'd1750;
	localparam logic [7:0]  BAD_LIMIT_RST         = 8'd10;

	// Valid pulse range and output levels.
	localparam logic [WIDTH_W-1:0] VALID_LO    = 15'd1000;
	localparam logic [WIDTH_W-1:0] VALID_HI    = 15'd2000;
	localparam logic [LEVEL_W-1:0] FULL_LEVEL  = 8'd255;
	localparam logic [LEVEL_W-1:0] BLINK_LEVEL = 8'd127;
	localparam logic [LEVEL_W-1:0] OFF_LEVEL   = 8'd0;
	localparam logic [7:0]         BAD_MAX     = 8'd255;

	// True when the phase modulo ten is 0, 1 or 2. The residue modulo five
	// comes from the nibble sum (16 is 1 modulo 5), the residue modulo two
	// from the low bit, and the pair picks the residue modulo ten.
	function automatic logic blink_on(input logic [15:0] phase);
		logic [5:0] nib_sum;
		logic [4:0] fold;
		logic [4:0] r5;
		logic       odd;
		nib_sum = {2'b00, phase[3:0]} + {2'b00, phase[7:4]}
			+ {2'b00, phase[11:8]} + {2'b00, phase[15:12]};
		fold = {3'b000, nib_sum[5:4]} + {1'b0, nib_sum[3:0]};
		if (fold >= 5'd15) begin
			r5 = fold - 5'd15;
		end else if (fold >= 5'd10) begin
			r5 = fold - 5'd10;
		end else if (fold >= 5'd5) begin
			r5 = fold - 5'd5;
		end else begin
			r5 = fold;
		end
		odd = phase[0];
		return ((r5 == 5'd0) && !odd) || ((r5 == 5'd1) && odd) || ((r5 == 5'd2) && !odd);
	endfunction

endpackage

`default_nettype wire

@@ design/rc_brake_hazard_light_controller_core.sv @@
// Top level of the RC brake and hazard light controller.
// A poll is first taken into the input register and moves on into the result
// register when that is empty or its beat is taken; the result beat is then offered.
// Throughput: one poll per cycle; the input register takes a new poll whenever
// it is empty or its poll moves on, so both sides stall only on the downstream tready.
// Reset (arst_n low, asynchronous): held widths, times and counters clear,
// throttle state is neutral, brake light flag is set, registers take defaults.
`timescale 1ns / 1ps
`default_nettype none

module rc_brake_hazard_light_controller_core
	import rcbhl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Poll input.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // now[31:0], thr_width[46:32], aux_width[61:47], zero pad
	// Light levels output.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // brake_level[7:0], hazard_level[15:8]
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	// Configuration registers.
	logic [11:0] brake_thr_q;
	logic [11:0] accel_thr_q;
	logic [7:0]  trigger_drop_q;
	logic [7:0]  position_level_q;
	logic [19:0] neutral_win_q;
	logic [19:0] fresh_win_q;
	logic [11:0] hazard_thr_q;
	logic [7:0]  bad_limit_q;

	// Input register.
	logic               valid_s1;
	logic [NOW_W-1:0]   now_s1;
	logic [WIDTH_W-1:0] thr_s1;
	logic [WIDTH_W-1:0] aux_s1;

	// Controller state.
	logic [WIDTH_W-1:0] thr_held_q;
	logic [NOW_W-1:0]   thr_seen_q;
	logic [WIDTH_W-1:0] aux_held_q;
	logic [NOW_W-1:0]   aux_seen_q;
	logic [7:0]         bad_count_q;
	thr_state_t         prev_state_q;
	logic [WIDTH_W-1:0] prev_width_q;
	logic [NOW_W-1:0]   change_time_q;
	logic               brake_on_q;
	logic               moved_q;

	// Result register.
	logic               out_valid_q;
	logic [LEVEL_W-1:0] brake_level_q;
	logic [LEVEL_W-1:0] hazard_level_q;

	// Next-state and result signals.
	logic               advance;
	logic [WIDTH_W-1:0] thr_held_n;
	logic [NOW_W-1:0]   thr_seen_n;
	logic [WIDTH_W-1:0] aux_held_n;
	logic [NOW_W-1:0]   aux_seen_n;
	logic [7:0]         bad_count_n;
	thr_state_t         prev_state_n;
	logic [WIDTH_W-1:0] prev_width_n;
	logic [NOW_W-1:0]   change_time_n;
	logic               brake_on_n;
	logic               moved_n;
	logic [LEVEL_W-1:0] brake_level_n;
	logic [LEVEL_W-1:0] hazard_level_n;
	logic               valid_w;
	logic               fresh;
	logic               active;
	logic               blink;
	logic               err;
	thr_state_t         cur_state;
	logic [NOW_W-1:0]   aux_age;
	logic [NOW_W-1:0]   thr_age;
	logic [NOW_W-1:0]   state_age;
	logic [WIDTH_W:0]   eased_sum;

	// The poll in the input register moves on when the result register is empty or its beat is taken.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {hazard_level_q, brake_level_q};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brake_thr_q      <= BRAKE_THRESHOLD_RST;
			accel_thr_q      <= ACCEL_THRESHOLD_RST;
			trigger_drop_q   <= TRIGGER_DROP_RST;
			position_level_q <= POSITION_LEVEL_RST;
			neutral_win_q    <= NEUTRAL_WINDOW_US_RST;
			fresh_win_q      <= FRESH_WINDOW_US_RST;
			hazard_thr_q     <= HAZARD_THRESHOLD_RST;
			bad_limit_q      <= BAD_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BRAKE_THRESHOLD:   brake_thr_q      <= cfg_data[11:0];
				REG_ACCEL_THRESHOLD:   accel_thr_q      <= cfg_data[11:0];
				REG_TRIGGER_DROP:      trigger_drop_q   <= cfg_data[7:0];
				REG_POSITION_LEVEL:    position_level_q <= cfg_data[7:0];
				REG_NEUTRAL_WINDOW_US: neutral_win_q    <= cfg_data;
				REG_FRESH_WINDOW_US:   fresh_win_q      <= cfg_data;
				REG_HAZARD_THRESHOLD:  hazard_thr_q     <= cfg_data[11:0];
				REG_BAD_LIMIT:         bad_limit_q      <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			now_s1 <= s_axis_tdata[31:0];
			thr_s1 <= s_axis_tdata[46:32];
			aux_s1 <= s_axis_tdata[61:47];
		end
	end

	// Held widths, validity, freshness and the bad-poll counter.
	always_comb begin
		thr_held_n = (thr_s1 != '0) ? thr_s1 : thr_held_q;
		thr_seen_n = (thr_s1 != '0) ? now_s1 : thr_seen_q;
		aux_held_n = (aux_s1 != '0) ? aux_s1 : aux_held_q;
		aux_seen_n = (aux_s1 != '0) ? now_s1 : aux_seen_q;

		valid_w = (aux_held_n >= VALID_LO) && (aux_held_n <= VALID_HI)
			&& (thr_held_n >= VALID_LO) && (thr_held_n <= VALID_HI);
		aux_age = now_s1 - aux_seen_n;
		thr_age = now_s1 - thr_seen_n;
		fresh   = (aux_age <= {12'd0, fresh_win_q}) && (thr_age <= {12'd0, fresh_win_q});

		if (valid_w && fresh) begin
			bad_count_n = '0;
		end else if (bad_count_q != BAD_MAX) begin
			bad_count_n = bad_count_q + 8'd1;
		end else begin
			bad_count_n = bad_count_q;
		end

		active = fresh && (bad_count_n < bad_limit_q);
		blink  = blink_on(now_s1[31:16]);
		err    = now_s1[19];
	end

	// Throttle state machine and light levels.
	always_comb begin
		prev_state_n  = prev_state_q;
		prev_width_n  = prev_width_q;
		change_time_n = change_time_q;
		brake_on_n    = brake_on_q;
		moved_n       = moved_q;
		state_age     = now_s1 - change_time_q;
		eased_sum     = {1'b0, thr_held_n} + {8'd0, trigger_drop_q};

		// Brake wins where the thresholds overlap.
		if (thr_held_n <= {3'd0, brake_thr_q}) begin
			cur_state = THR_BRAKE;
		end else if (thr_held_n >= {3'd0, accel_thr_q}) begin
			cur_state = THR_ACCEL;
		end else begin
			cur_state = THR_NEUTRAL;
		end

		if (active) begin
			moved_n = moved_q || (cur_state != THR_NEUTRAL);
			if (!moved_n) begin
				// Until the throttle first moves, the brake light blinks.
				brake_level_n = blink ? BLINK_LEVEL : OFF_LEVEL;
			end else begin
				if (cur_state != prev_state_q) begin
					case (cur_state)
						THR_ACCEL:   brake_on_n = 1'b0;
						THR_NEUTRAL: brake_on_n = 1'b1;
						THR_BRAKE: begin
							if (prev_state_q == THR_NEUTRAL
								&& state_age < {12'd0, neutral_win_q}) begin
								brake_on_n = 1'b1;
							end else if (prev_state_q == THR_ACCEL) begin
								brake_on_n = 1'b1;
							end else begin
								brake_on_n = 1'b0;
							end
						end
						default: brake_on_n = brake_on_q;
					endcase
					change_time_n = now_s1;
					prev_state_n  = cur_state;
				end
				// In accel, a width drop over the trigger drop lights the brake; other changes clear it.
				if (thr_held_n != prev_width_q && cur_state == THR_ACCEL
					&& prev_state_q == THR_ACCEL) begin
					brake_on_n = eased_sum < {1'b0, prev_width_q};
				end
				prev_width_n  = thr_held_n;
				brake_level_n = brake_on_n ? FULL_LEVEL : position_level_q;
			end
			hazard_level_n = (aux_held_n > {3'd0, hazard_thr_q} && blink)
				? FULL_LEVEL : OFF_LEVEL;
		end else begin
			// Error pattern alternates the two lights.
			brake_level_n  = err ? OFF_LEVEL : FULL_LEVEL;
			hazard_level_n = err ? FULL_LEVEL : OFF_LEVEL;
		end
	end

	// Controller state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_held_q    <= '0;
			thr_seen_q    <= '0;
			aux_held_q    <= '0;
			aux_seen_q    <= '0;
			bad_count_q   <= '0;
			prev_state_q  <= THR_NEUTRAL;
			prev_width_q  <= '0;
			change_time_q <= '0;
			brake_on_q    <= 1'b1;
			moved_q       <= 1'b0;
		end else if (advance) begin
			thr_held_q    <= thr_held_n;
			thr_seen_q    <= thr_seen_n;
			aux_held_q    <= aux_held_n;
			aux_seen_q    <= aux_seen_n;
			bad_count_q   <= bad_count_n;
			prev_state_q  <= prev_state_n;
			prev_width_q  <= prev_width_n;
			change_time_q <= change_time_n;
			brake_on_q    <= brake_on_n;
			moved_q       <= moved_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			brake_level_q  <= brake_level_n;
			hazard_level_q <= hazard_level_n;
		end
	end

endmodule

`default_nettype wire
